### design/weighted_kmeans_engine_core_assert.svh
// Assertion macros for the weighted k-means engine checker.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef WEIGHTED_KMEANS_ENGINE_CORE_ASSERT_SVH
`define WEIGHTED_KMEANS_ENGINE_CORE_ASSERT_SVH

// implication checked on every rising clock edge, off while in reset
`define WKE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// signal must hold its value into the next cycle when the condition is true
`define WKE_ASSERT_HOLD(lbl, cond, sig, msg) \
	`WKE_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

### design/wke_pkg.sv
// Shared types and constants for the weighted k-means engine.
// Used by weighted_kmeans_engine_core and its port checker.
package wke_pkg;

	localparam int MaxClusters = 16;
	localparam int MaxDims     = 128;
	localparam int SampleBits  = 16;
	localparam int CountBits   = 17;
	localparam int DistBits    = 41;
	localparam int CompBits    = 57;
	localparam int SumBits     = 48;
	localparam int KBits       = 4;
	localparam int JBits       = 7;
	localparam int AddrBits    = KBits + JBits;
	localparam int MemDepth    = MaxClusters * MaxDims;
	localparam int FBits       = SumBits - 8;
	localparam int InDataBits  = 48;
	localparam int OutDataBits = 176;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_LABEL  = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_DIST_RD, ST_DIST_MUL, ST_DIST_ACC, ST_ARG_INIT, ST_ARGMIN,
		ST_SUM_RD, ST_SUM_MUL, ST_SUM_ACC, ST_FIN, ST_UPD_RD, ST_UPD_F, ST_UPD_DIV,
		ST_UPD_SAT, ST_UPD_ACC, ST_UPD_ROW, ST_EMIT
	} state_t;

	localparam logic [DistBits-1:0] DistMax = '1;
	localparam logic [CompBits-1:0] CompMax = '1;
	localparam logic [CountBits-1:0] CntMax = '1;

endpackage

### design/weighted_kmeans_engine_core.sv
// Weighted k-means pass engine: center store, weighted sums, divider sequencer.
// Depends on wke_pkg.
//
// Usage: input words arrive on s_axis (tuser = opcode, tlast = last element of a
// sample), results leave on m_axis (tuser = result kind). Registers dims_in_use
// (index 0) and clusters_in_use (index 1) are written through cfg_we.
// All work runs through one 18x18 multiplier and one radix-2 divider under a
// sequencer; the block takes one word at a time.
// Steps per word:
//   load: a single store write. readback: memory read, then the result register.
//   sample element: memory read, multiply, accumulate per active center.
//   last element adds an argmin scan, weighted sum writes and the emit.
//   update: 2048 element slots and 16 row slots, then the emit; an active
//   element of a non-empty center also runs the 40-step divider.
// Reset: a clearing pass over all 2048 entries zeroes the weighted sums; no word is
// accepted meanwhile, config writes are taken.
// Stall: one output register; the block takes new words while a result waits,
// and holds in its final step only if a new result finds the register full.
module weighted_kmeans_engine_core
	import wke_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// center_index[3:0], element_index[10:4], value[26:11], weight[42:27], zero pad
	input  logic [InDataBits-1:0]  s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// label[3:0], min_distance[44:4], max_shift[85:45], compactness[142:86],
	// empty_clusters[158:143], center_value[174:159], zero pad
	output logic [OutDataBits-1:0] m_axis_tdata,
	// result_kind[1:0]
	output logic [1:0]             m_axis_tuser
);

	state_t state_q, state_d;

	logic [7:0] dims_q;
	logic [4:0] clus_q;
	logic [7:0] d_eff;
	logic [4:0] k_eff;

	logic [SampleBits-1:0] cmem [MemDepth];
	logic [SumBits-1:0]    smem [MemDepth];
	logic [SampleBits-1:0] bmem [MaxDims];

	logic                  cmem_we, cmem_re, smem_we, smem_re, bmem_we, bmem_re;
	logic [AddrBits-1:0]   cmem_wa, cmem_ra, smem_wa, smem_ra;
	logic [SampleBits-1:0] cmem_wd, cmem_rd_q;
	logic [SumBits-1:0]    smem_wd, smem_rd_q;
	logic [JBits-1:0]      bmem_wa, bmem_ra;
	logic [SampleBits-1:0] bmem_rd_q;

	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod_q;

	logic [DistBits-1:0]  part_q [MaxClusters];
	logic [CountBits-1:0] cnt_q [MaxClusters];
	logic [7:0]           ec_q;
	logic [CompBits-1:0]  comp_q;
	logic [4:0]           k_q;
	logic [7:0]           j_q;
	logic [3:0]           best_q;
	logic [DistBits-1:0]  bd_q, sh_q, maxs_q;
	logic [15:0]          empty_q;
	kind_t                kind_q;
	logic [SampleBits-1:0] val_q;
	logic [15:0]          w_q;
	logic                 last_q;
	logic [AddrBits-1:0]  clr_q;

	logic [FBits-1:0]     dvd_q;
	logic [CountBits-1:0] rem_q;
	logic [5:0]           dcnt_q;
	logic                 neg_q;

	logic                  out_v_q;
	kind_t                 out_kind_q;
	logic [OutDataBits-1:0] out_data_q;
	logic [OutDataBits-1:0] emit_data;

	logic in_fire, out_free, upd_active, dist_done, row_end;
	opcode_t in_op;
	logic signed [16:0] dist_diff, upd_diff;
	logic [SampleBits-1:0] nv;
	logic [DistBits:0] part_sum, sh_sum;
	logic [CompBits:0] comp_sum;
	logic signed [SumBits:0] acc_sum;
	logic [SumBits-1:0] acc_sat;
	logic signed [FBits-1:0] f_val;
	logic [CountBits:0] trial;
	logic qbit;

	// effective register values
	always_comb begin
		if (dims_q == 8'd0) d_eff = 8'd1;
		else if (dims_q > 8'(MaxDims)) d_eff = 8'(MaxDims);
		else d_eff = dims_q;
		if (clus_q == 5'd0) k_eff = 5'd1;
		else if (clus_q > 5'(MaxClusters)) k_eff = 5'(MaxClusters);
		else k_eff = clus_q;
	end

	assign in_op         = opcode_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_v_q || m_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	assign upd_active = (k_q < k_eff) && (cnt_q[k_q[3:0]] != '0) && ({1'b0, j_q[6:0]} < d_eff);
	assign dist_done  = (k_q + 5'd1) == k_eff;
	assign row_end    = (j_q[6:0] == 7'(MaxDims - 1));

	// datapath arithmetic
	assign dist_diff = 17'(signed'(val_q)) - 17'(signed'(cmem_rd_q));
	assign f_val     = FBits'(signed'(smem_rd_q) >>> 8);
	assign trial     = {rem_q, dvd_q[FBits-1]};
	assign qbit      = trial >= {1'b0, cnt_q[k_q[3:0]]};
	always_comb begin
		if (!neg_q) nv = (dvd_q > FBits'(32767)) ? 16'h7fff : dvd_q[15:0];
		else nv = (dvd_q > FBits'(32768)) ? 16'h8000 : 16'(~dvd_q[15:0] + 16'd1);
	end
	assign upd_diff = 17'(signed'(nv)) - 17'(signed'(cmem_rd_q));
	assign part_sum = {1'b0, part_q[k_q[3:0]]} + (DistBits+1)'(prod_q);
	assign sh_sum   = {1'b0, sh_q} + (DistBits+1)'(prod_q);
	assign comp_sum = {1'b0, comp_q} + (CompBits+1)'(bd_q);
	assign acc_sum  = (SumBits+1)'(signed'(smem_rd_q)) + (SumBits+1)'(prod_q);
	always_comb begin
		if (acc_sum[SumBits] != acc_sum[SumBits-1])
			acc_sat = acc_sum[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
				: {1'b0, {(SumBits-1){1'b1}}};
		else acc_sat = acc_sum[SumBits-1:0];
	end

	// result word for the kind being emitted
	always_comb begin
		emit_data = '0;
		unique case (kind_q)
			KIND_LABEL: begin
				emit_data[3:0]  = best_q;
				emit_data[44:4] = bd_q;
			end
			KIND_UPDATE: begin
				emit_data[85:45]   = maxs_q;
				emit_data[142:86]  = comp_q;
				emit_data[158:143] = empty_q;
			end
			KIND_READ: emit_data[174:159] = cmem_rd_q;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: if (clr_q == AddrBits'(MemDepth - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_op)
						OP_LOAD:   state_d = ST_IDLE;
						OP_READ:   state_d = ST_EMIT;
						OP_UPDATE: state_d = ST_UPD_RD;
						OP_SAMPLE: begin
							if (ec_q < d_eff) state_d = ST_DIST_RD;
							else if (s_axis_tlast) state_d = ST_ARG_INIT;
							else state_d = ST_IDLE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIST_RD:  state_d = ST_DIST_MUL;
			ST_DIST_MUL: state_d = ST_DIST_ACC;
			ST_DIST_ACC: begin
				if (!dist_done) state_d = ST_DIST_RD;
				else if (last_q) state_d = ST_ARG_INIT;
				else state_d = ST_IDLE;
			end
			ST_ARG_INIT: state_d = ST_ARGMIN;
			ST_ARGMIN: if (k_q >= k_eff) state_d = (ec_q == 8'd0) ? ST_FIN : ST_SUM_RD;
			ST_SUM_RD:   state_d = ST_SUM_MUL;
			ST_SUM_MUL:  state_d = ST_SUM_ACC;
			ST_SUM_ACC:  state_d = ((j_q + 8'd1) == ec_q) ? ST_FIN : ST_SUM_RD;
			ST_FIN:      state_d = ST_EMIT;
			ST_UPD_RD: begin
				if (upd_active) state_d = ST_UPD_F;
				else if (row_end) state_d = ST_UPD_ROW;
			end
			ST_UPD_F:   state_d = ST_UPD_DIV;
			ST_UPD_DIV: if (dcnt_q == 6'd1) state_d = ST_UPD_SAT;
			ST_UPD_SAT: state_d = ST_UPD_ACC;
			ST_UPD_ACC: state_d = row_end ? ST_UPD_ROW : ST_UPD_RD;
			ST_UPD_ROW: state_d = (k_q[3:0] == 4'(MaxClusters - 1)) ? ST_EMIT : ST_UPD_RD;
			ST_EMIT:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory ports and multiplier operands
	always_comb begin
		cmem_we = 1'b0; cmem_wa = '0; cmem_wd = '0;
		cmem_re = 1'b0; cmem_ra = '0;
		smem_we = 1'b0; smem_wa = '0; smem_wd = '0;
		smem_re = 1'b0; smem_ra = '0;
		bmem_we = 1'b0; bmem_wa = '0;
		bmem_re = 1'b0; bmem_ra = '0;
		mul_a   = '0;   mul_b   = '0;
		unique case (state_q)
			ST_CLR: begin
				smem_we = 1'b1; smem_wa = clr_q;
			end
			ST_IDLE: begin
				// store address is center * MaxDims + element
				if (in_fire && in_op == OP_LOAD) begin
					cmem_we = 1'b1;
					cmem_wa = {s_axis_tdata[3:0], s_axis_tdata[10:4]};
					cmem_wd = s_axis_tdata[26:11];
				end
				if (in_fire && in_op == OP_READ) begin
					cmem_re = 1'b1;
					cmem_ra = {s_axis_tdata[3:0], s_axis_tdata[10:4]};
				end
				if (in_fire && in_op == OP_SAMPLE && ec_q < d_eff) begin
					bmem_we = 1'b1;
					bmem_wa = ec_q[6:0];
				end
			end
			ST_DIST_RD: begin
				cmem_re = 1'b1; cmem_ra = {k_q[3:0], ec_q[6:0]};
			end
			ST_DIST_MUL: begin
				mul_a = 18'(dist_diff); mul_b = 18'(dist_diff);
			end
			ST_SUM_RD: begin
				smem_re = 1'b1; smem_ra = {best_q, j_q[6:0]};
				bmem_re = 1'b1; bmem_ra = j_q[6:0];
			end
			ST_SUM_MUL: begin
				mul_a = {2'b00, w_q}; mul_b = 18'(signed'(bmem_rd_q));
			end
			ST_SUM_ACC: begin
				smem_we = 1'b1; smem_wa = {best_q, j_q[6:0]}; smem_wd = acc_sat;
			end
			ST_UPD_RD: begin
				if (upd_active) begin
					smem_re = 1'b1; smem_ra = {k_q[3:0], j_q[6:0]};
					cmem_re = 1'b1; cmem_ra = {k_q[3:0], j_q[6:0]};
				end else begin
					smem_we = 1'b1; smem_wa = {k_q[3:0], j_q[6:0]};
				end
			end
			ST_UPD_SAT: begin
				cmem_we = 1'b1; cmem_wa = {k_q[3:0], j_q[6:0]}; cmem_wd = nv;
				smem_we = 1'b1; smem_wa = {k_q[3:0], j_q[6:0]};
				mul_a   = 18'(upd_diff); mul_b = 18'(upd_diff);
			end
			default: ;
		endcase
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (cmem_we) cmem[cmem_wa] <= cmem_wd;
		if (cmem_re) cmem_rd_q <= cmem[cmem_ra];
		if (smem_we) smem[smem_wa] <= smem_wd;
		if (smem_re) smem_rd_q <= smem[smem_ra];
		if (bmem_we) bmem[bmem_wa] <= s_axis_tdata[26:11];
		if (bmem_re) bmem_rd_q <= bmem[bmem_ra];
		prod_q <= mul_a * mul_b;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_q  <= s_axis_tdata[26:11];
			w_q    <= s_axis_tdata[42:27];
			last_q <= s_axis_tlast;
		end
		unique case (state_q)
			ST_UPD_F: begin
				neg_q  <= f_val[FBits-1];
				dvd_q  <= f_val[FBits-1] ? FBits'(-f_val) : FBits'(f_val);
				rem_q  <= '0;
				dcnt_q <= 6'(FBits);
			end
			ST_UPD_DIV: begin
				// one quotient bit per cycle
				rem_q  <= qbit ? CountBits'(trial - {1'b0, cnt_q[k_q[3:0]]})
					: trial[CountBits-1:0];
				dvd_q  <= {dvd_q[FBits-2:0], qbit};
				dcnt_q <= dcnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	// control and pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			dims_q     <= 8'(MaxDims);
			clus_q     <= 5'(MaxClusters);
			clr_q      <= '0;
			ec_q       <= '0;
			comp_q     <= '0;
			k_q        <= '0;
			j_q        <= '0;
			best_q     <= '0;
			bd_q       <= '0;
			sh_q       <= '0;
			maxs_q     <= '0;
			empty_q    <= '0;
			kind_q     <= KIND_LABEL;
			out_v_q    <= 1'b0;
			out_kind_q <= KIND_LABEL;
			out_data_q <= '0;
			for (int i = 0; i < MaxClusters; i++) begin
				part_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index) clus_q <= cfg_wdata[4:0];
				else dims_q <= cfg_wdata;
			end
			if (state_q == ST_EMIT && out_free) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_CLR: clr_q <= clr_q + AddrBits'(1);
				ST_IDLE: begin
					if (in_fire) begin
						k_q <= '0;
						j_q <= '0;
						if (in_op == OP_READ) kind_q <= KIND_READ;
						if (in_op == OP_UPDATE) begin
							kind_q  <= KIND_UPDATE;
							ec_q    <= '0;
							sh_q    <= '0;
							maxs_q  <= '0;
							empty_q <= '0;
							for (int i = 0; i < MaxClusters; i++) part_q[i] <= '0;
						end
					end
				end
				ST_DIST_ACC: begin
					part_q[k_q[3:0]] <= part_sum[DistBits] ? DistMax : part_sum[DistBits-1:0];
					k_q <= k_q + 5'd1;
					if (dist_done) ec_q <= ec_q + 8'd1;
				end
				ST_ARG_INIT: begin
					bd_q   <= part_q[0];
					best_q <= '0;
					k_q    <= 5'd1;
					j_q    <= '0;
				end
				ST_ARGMIN: begin
					if (k_q < k_eff) begin
						// strict compare keeps the lower index on a tie
						if (part_q[k_q[3:0]] < bd_q) begin
							bd_q   <= part_q[k_q[3:0]];
							best_q <= k_q[3:0];
						end
						k_q <= k_q + 5'd1;
					end
				end
				ST_SUM_ACC: j_q <= j_q + 8'd1;
				ST_FIN: begin
					if (cnt_q[best_q] != CntMax) cnt_q[best_q] <= cnt_q[best_q] + CountBits'(1);
					comp_q <= comp_sum[CompBits] ? CompMax : comp_sum[CompBits-1:0];
					ec_q   <= '0;
					kind_q <= KIND_LABEL;
					for (int i = 0; i < MaxClusters; i++) part_q[i] <= '0;
				end
				ST_UPD_RD: if (!upd_active && !row_end) j_q <= j_q + 8'd1;
				ST_UPD_ACC: begin
					sh_q <= sh_sum[DistBits] ? DistMax : sh_sum[DistBits-1:0];
					if (!row_end) j_q <= j_q + 8'd1;
				end
				ST_UPD_ROW: begin
					if (k_q < k_eff) begin
						if (cnt_q[k_q[3:0]] == '0) empty_q[k_q[3:0]] <= 1'b1;
						else if (sh_q > maxs_q) maxs_q <= sh_q;
					end
					sh_q <= '0;
					j_q  <= '0;
					k_q  <= k_q + 5'd1;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_kind_q <= kind_q;
						out_data_q <= emit_data;
						if (kind_q == KIND_UPDATE) begin
							comp_q <= '0;
							for (int i = 0; i < MaxClusters; i++) cnt_q[i] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### design/wke_checker.sv
// Port-level checker for weighted_kmeans_engine_core, attached by bind.
// Depends on wke_pkg and weighted_kmeans_engine_core_assert.svh.
`include "weighted_kmeans_engine_core_assert.svh"

module wke_checker
	import wke_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [1:0]             s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OutDataBits-1:0] m_axis_tdata,
	input logic [1:0]             m_axis_tuser
);

	`WKE_ASSERT_HOLD(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result word changed while stalled")
	`WKE_ASSERT(a_kind_ok, m_axis_tvalid |-> (m_axis_tuser != KIND_NONE), "undefined result kind")
	`WKE_ASSERT(a_label_clean, (m_axis_tvalid && m_axis_tuser == KIND_LABEL) |-> (m_axis_tdata[175:45] == '0), "label word carries other fields")
	`WKE_ASSERT(a_read_clean, (m_axis_tvalid && m_axis_tuser == KIND_READ) |-> (m_axis_tdata[158:0] == '0), "readback word carries other fields")
	`WKE_ASSERT(a_busy_after, (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_READ || s_axis_tuser == OP_UPDATE)) |=> !s_axis_tready, "ready right after a read or update")

endmodule

bind weighted_kmeans_engine_core wke_checker u_wke_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### sim/wke_stream_checker.sv
// Stream checker for weighted_kmeans_engine_core: watches the config port and
// both stream channels, predicts every result and compares it. Depends on wke_pkg.
module wke_stream_checker
	import wke_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [InDataBits-1:0]  s_axis_tdata,
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OutDataBits-1:0] m_axis_tdata,
	input  logic [1:0]             m_axis_tuser,
	output int                     errors,
	output int                     pending
);

	typedef struct {
		kind_t                kind;
		logic [3:0]           label;
		logic [DistBits-1:0]  near_dist;
		logic [DistBits-1:0]  max_shift;
		logic [CompBits-1:0]  compact;
		logic [15:0]          empty;
		logic [15:0]          cval;
	} result_t;

	localparam longint SumHi = (longint'(1) << 47) - 1;
	localparam longint SumLo = -SumHi - 1;

	result_t             expected_q[$];
	logic [7:0]          dims_reg;
	logic [4:0]          clus_reg;
	logic signed [15:0]  centers[MemDepth];
	longint              wsums[MemDepth];
	int                  members[MaxClusters];
	longint unsigned     part_dist[MaxClusters];
	logic signed [15:0]  smp_buf[MaxDims];
	int                  elem_cnt;
	longint unsigned     pass_comp;

	assign pending = expected_q.size();

	function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
			longint unsigned lim);
		longint unsigned s;
		s = a + b;
		return (s > lim) ? lim : s;
	endfunction

	function automatic longint unsigned sq_diff(longint a, longint b);
		longint d;
		d = a - b;
		return longint'(d * d);
	endfunction

	function automatic int dims_eff();
		if (dims_reg == 0) return 1;
		return (dims_reg > MaxDims) ? MaxDims : dims_reg;
	endfunction

	function automatic int clus_eff();
		if (clus_reg == 0) return 1;
		return (clus_reg > MaxClusters) ? MaxClusters : clus_reg;
	endfunction

	task automatic clear_sample();
		elem_cnt = 0;
		foreach (part_dist[k]) part_dist[k] = 0;
	endtask

	task automatic model_reset();
		dims_reg = 8'd128;
		clus_reg = 5'd16;
		foreach (centers[i]) centers[i] = '0;
		foreach (wsums[i]) wsums[i] = 0;
		foreach (members[k]) members[k] = 0;
		pass_comp = 0;
		clear_sample();
		expected_q.delete();
	endtask

	// one accepted input word in, at most one expected result queued
	task automatic predict_word(opcode_t op, int ci, int ei, logic signed [15:0] val,
			int w, logic last);
		result_t r;
		int d, kk, best, n, c;
		longint unsigned bd, sh, maxs;
		longint t, s, f, q;
		logic [15:0] empty;
		d = dims_eff();
		kk = clus_eff();
		r = '{KIND_LABEL, '0, '0, '0, '0, '0, '0};
		case (op)
			OP_LOAD: begin
				centers[ci * MaxDims + ei] = val;
			end
			OP_READ: begin
				r.kind = KIND_READ;
				r.cval = centers[ci * MaxDims + ei];
				expected_q.push_back(r);
			end
			OP_SAMPLE: begin
				if (elem_cnt < d) begin
					smp_buf[elem_cnt] = val;
					for (int k = 0; k < kk; k++)
						part_dist[k] = sat_add(part_dist[k],
							sq_diff(val, centers[k * MaxDims + elem_cnt]), DistMax);
					elem_cnt++;
				end
				if (last) begin
					n = elem_cnt;
					best = 0;
					bd = part_dist[0];
					for (int k = 1; k < kk; k++)
						if (part_dist[k] < bd) begin
							bd = part_dist[k];
							best = k;
						end
					for (int j = 0; j < n; j++) begin
						t = wsums[best * MaxDims + j] + longint'(w) * longint'(smp_buf[j]);
						wsums[best * MaxDims + j] = (t > SumHi) ? SumHi : ((t < SumLo) ? SumLo : t);
					end
					if (members[best] < int'(CntMax)) members[best]++;
					pass_comp = sat_add(pass_comp, bd, CompMax);
					clear_sample();
					r.kind = KIND_LABEL;
					r.label = best[3:0];
					r.near_dist = bd[DistBits-1:0];
					expected_q.push_back(r);
				end
			end
			default: begin
				clear_sample();
				maxs = 0;
				empty = '0;
				for (int k = 0; k < kk; k++) begin
					c = members[k];
					sh = 0;
					if (c == 0) begin
						empty[k] = 1'b1;
						continue;
					end
					for (int j = 0; j < d; j++) begin
						s = wsums[k * MaxDims + j];
						// floor of sum/256, then divide truncating toward zero
						f = (s < 0) ? -(((-s) + 255) >>> 8) : (s >>> 8);
						q = f / c;
						if (q > 32767) q = 32767;
						if (q < -32768) q = -32768;
						sh = sat_add(sh, sq_diff(q, centers[k * MaxDims + j]), DistMax);
						centers[k * MaxDims + j] = q[15:0];
					end
					if (sh > maxs) maxs = sh;
				end
				r.kind = KIND_UPDATE;
				r.max_shift = maxs[DistBits-1:0];
				r.compact = pass_comp[CompBits-1:0];
				r.empty = empty;
				expected_q.push_back(r);
				foreach (wsums[i]) wsums[i] = 0;
				foreach (members[k]) members[k] = 0;
				pass_comp = 0;
			end
		endcase
	endtask

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic check_word();
		result_t r;
		if (expected_q.size() == 0) begin
			report("unexpected word, kind", m_axis_tuser, 0);
			return;
		end
		r = expected_q.pop_front();
		if (m_axis_tuser != r.kind) report("result_kind", m_axis_tuser, r.kind);
		if (m_axis_tdata[3:0] != r.label) report("label", m_axis_tdata[3:0], r.label);
		if (m_axis_tdata[44:4] != r.near_dist)
			report("min_distance", m_axis_tdata[44:4], r.near_dist);
		if (m_axis_tdata[85:45] != r.max_shift) report("max_shift", m_axis_tdata[85:45], r.max_shift);
		if (m_axis_tdata[142:86] != r.compact) report("compactness", m_axis_tdata[142:86], r.compact);
		if (m_axis_tdata[158:143] != r.empty)
			report("empty_clusters", m_axis_tdata[158:143], r.empty);
		if (m_axis_tdata[174:159] != r.cval) report("center_value", m_axis_tdata[174:159], r.cval);
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_reset();
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'b0) dims_reg = cfg_wdata;
				else clus_reg = cfg_wdata[4:0];
			end
			// outgoing word belongs to an older item, so retire it first
			if (m_axis_tvalid && m_axis_tready) check_word();
			if (s_axis_tvalid && s_axis_tready)
				predict_word(opcode_t'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[10:4],
					s_axis_tdata[26:11], s_axis_tdata[42:27], s_axis_tlast);
		end
	end

endmodule

### sim/weighted_kmeans_engine_core_tb.sv
// Top of the weighted k-means engine testbench: clock, reset, stimulus, verdict.
// Depends on wke_pkg, weighted_kmeans_engine_core and wke_stream_checker.
module weighted_kmeans_engine_core_tb
	import wke_pkg::*;
();

	localparam int IdleLimit  = 40000;
	localparam int LoadedDims = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [7:0]             cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [InDataBits-1:0]  s_axis_tdata;
	logic [1:0]             s_axis_tuser;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OutDataBits-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	int                     errors;
	int                     pending;
	int                     burst_left;
	int                     idle_cycles;
	int                     stall_mode;
	int                     stall_left;
	int                     dims_now;
	int                     phase_words;

	weighted_kmeans_engine_core DUT (.*);

	wke_stream_checker checker_i (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver: switches between always ready, random and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(10, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(opcode_t op, logic [3:0] ci, logic [6:0] ei,
			logic signed [15:0] val, logic [15:0] w, logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		s_axis_tdata <= {5'b0, w, val, ei, ci};
		do @(posedge clk); while (!s_axis_tready);
		phase_words++;
		burst_left--;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 16);
		end
	endtask

	task automatic send_sample(int len, logic [15:0] w);
		for (int j = 0; j < len; j++)
			send_word(OP_SAMPLE, 4'($urandom), 7'($urandom), rand_value(), w, j == len - 1);
	endtask

	task automatic send_update();
		send_word(OP_UPDATE, 4'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom));
	endtask

	// registers change only with no word in flight
	task automatic set_config(logic [7:0] dims, logic [4:0] clus);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 1'b0;
		cfg_wdata <= dims;
		@(posedge clk);
		cfg_index <= 1'b1;
		cfg_wdata <= {3'b0, clus};
		@(posedge clk);
		cfg_we <= 1'b0;
		dims_now = (dims == 0) ? 1 : ((dims > MaxDims) ? MaxDims : dims);
	endtask

	// loads and reads stay inside the loaded part of the center store
	task automatic random_phase(int budget);
		int r;
		phase_words = 0;
		while (phase_words < budget) begin
			r = $urandom_range(0, 99);
			if (r < 68)
				send_sample(dims_now, rand_weight());
			else if (r < 76)
				send_sample($urandom_range(1, dims_now), rand_weight());
			else if (r < 82)
				send_sample(dims_now + $urandom_range(1, 3), rand_weight());
			else if (r < 89)
				send_word(OP_READ, 4'($urandom), 7'($urandom_range(0, LoadedDims - 1)),
					16'($urandom), 16'($urandom), 1'($urandom));
			else if (r < 95)
				send_word(OP_LOAD, 4'($urandom), 7'($urandom_range(0, LoadedDims - 1)),
					rand_value(), 16'($urandom), 1'($urandom));
			else begin
				// abandoned sample followed by an update
				send_word(OP_SAMPLE, 4'd0, 7'd0, rand_value(), rand_weight(), 1'b0);
				send_update();
			end
		end
		send_update();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_LOAD;
		s_axis_tlast = 1'b0;
		idle_cycles = 0;
		burst_left = 8;
		dims_now = MaxDims;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// center 0 gets every element, the others the first LoadedDims
		for (int j = 0; j < MaxDims; j++)
			send_word(OP_LOAD, 4'd0, 7'(j), rand_value(), 16'($urandom), 1'($urandom));
		for (int k = 1; k < MaxClusters; k++)
			for (int j = 0; j < LoadedDims; j++)
				send_word(OP_LOAD, 4'(k), 7'(j), rand_value(), 16'($urandom), 1'($urandom));

		// directed: extremes, ties, short and long samples, empty update
		set_config(8'd2, 5'd16);
		send_word(OP_LOAD, 4'd0, 7'd0, 16'sh8000, 16'hFFFF, 1'b1);
		send_word(OP_LOAD, 4'd15, 7'd127, 16'sh7FFF, 16'h0000, 1'b0);
		send_word(OP_READ, 4'd0, 7'd0, 16'sh0, 16'h0, 1'b0);
		send_word(OP_READ, 4'd15, 7'd127, 16'sh0, 16'h0, 1'b1);
		for (int k = 0; k < 2; k++)
			for (int j = 0; j < 2; j++)
				send_word(OP_LOAD, 4'(k), 7'(j), 16'sh0100, 16'h0, 1'b0);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh0100, 16'hFFFF, 1'b0);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh0100, 16'hFFFF, 1'b1);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh7FFF, 16'h0000, 1'b1);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh8000, 16'h0100, 1'b0);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh8000, 16'h0100, 1'b0);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh7FFF, 16'h0100, 1'b1);
		send_word(OP_UPDATE, 4'd0, 7'd0, 16'sh0, 16'h0, 1'b0);
		send_word(OP_READ, 4'd0, 7'd1, 16'sh0, 16'h0, 1'b0);
		send_word(OP_SAMPLE, 4'd0, 7'd0, 16'sh1234, 16'h0100, 1'b0);
		send_word(OP_UPDATE, 4'd0, 7'd0, 16'sh0, 16'h0, 1'b0);

		set_config(8'd1, 5'd1);
		random_phase(20);
		set_config(8'd0, 5'd0);
		random_phase(10);
		set_config(8'd2, 5'd31);
		random_phase(20);
		// full-width sample on center 0 with extra elements past the end
		set_config(8'd255, 5'd0);
		send_sample(MaxDims + 2, rand_weight());
		send_update();
		repeat (4) begin
			set_config(8'($urandom_range(1, LoadedDims)), 5'($urandom_range(0, 31)));
			random_phase(20);
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/wke_pkg.sv
design/weighted_kmeans_engine_core.sv
design/wke_checker.sv
sim/wke_stream_checker.sv
sim/weighted_kmeans_engine_core_tb.sv
